[rtl/mnnt_pkg.sv]
package mnnt_pkg;

   // fixed field widths of the result item and the csr
   localparam int CITY_W     = 7;
   localparam int COST_OUT_W = 22;
   localparam int CSR_W      = 7;

   // cost register starts above any real tour cost
   localparam logic [22:0] BEST_INIT = 23'h7F_FFFF;
   localparam logic [CSR_W-1:0] CSR_RESET = 7'd64;

   typedef enum logic [3:0] {
      S_LOAD,
      S_START,
      S_SCAN,
      S_SCAN_END,
      S_COMMIT,
      S_CLOSE,
      S_CLOSE_ADD,
      S_TOUR_END,
      S_OUT_RD,
      S_OUT_LOAD
   } mnnt_state_type;

endpackage

[rtl/mnnt_if.sv]
interface mnnt_req_if #(
   parameter int DIST_WIDTH = 16
);
   logic                  valid;
   logic                  ready;
   logic [DIST_WIDTH-1:0] distance;

   modport source (output valid, output distance, input ready);
   modport sink (input valid, input distance, output ready);
endinterface

interface mnnt_rsp_if
   import mnnt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CITY_W-1:0]     city;
   logic [COST_OUT_W-1:0] tour_cost;
   logic                  last;

   modport source (output valid, output city, output tour_cost, output last, input ready);
   modport sink (input valid, input city, input tour_cost, input last, output ready);
endinterface

[rtl/multi_start_nearest_neighbor_tour.sv]
// multi-start nearest-neighbor tour builder
//
// req channel: one distance item per accepted handshake, the n-by-n matrix in
//   row-major order, c(1,1) first. ready is high only while loading.
// csr port: csr_wr_en / csr_wr_data set the city count n (0 acts as 1, values
//   above MAX_CITIES act as MAX_CITIES). a write also restarts the load at
//   c(1,1). write it only while the block is idle.
// rsp channel: after the last matrix item the block searches, then sends the
//   n cities of the cheapest closed tour in order, each with the tour cost,
//   last set on the final city.
// timing: loading writes each accepted item to the distance ram. the search
//   walks every start city with one shared compare/add unit fed by the
//   distance ram read port, one distance per cycle. each result city is read
//   from the tour ram in S_OUT_RD and loaded into the result register in
//   S_OUT_LOAD; the block reads no new city until the previous one is loaded.
// stalls: the result register holds its item until rsp.ready; the next tour
//   ram read waits for it. once the last city is in the result register the
//   block goes back to loading.
// reset: synchronous, n returns to 64, the load restarts and pending results
//   are dropped. matrix and tour storage keep their contents.
module multi_start_nearest_neighbor_tour
   import mnnt_pkg::*;
#(
   parameter int MAX_CITIES = 64,
   parameter int DIST_WIDTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   mnnt_req_if.sink          req,
   mnnt_rsp_if.source        rsp,
   input  logic              csr_wr_en,
   input  logic [CSR_W-1:0]  csr_wr_data
);

   localparam int IDX_W   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int DIST_AW = 2 * IDX_W;
   localparam int TOUR_AW = IDX_W + 1;
   localparam int SUM_W   = DIST_WIDTH + IDX_W + 1;
   localparam int COST_W  = (SUM_W > 23) ? SUM_W : 23;
   localparam logic [CSR_W-1:0] MAX_N = CSR_W'(MAX_CITIES);

   // sequencer and csr
   mnnt_state_type state_ff, state_in;
   logic [CSR_W-1:0] count_ff, count_in;
   logic [CSR_W-1:0] n_clamp;
   logic [IDX_W-1:0] n_last;

   // load position
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;

   // search state
   logic [IDX_W-1:0]      st_ff, st_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [IDX_W-1:0]      prev_ff, prev_in;
   logic [IDX_W-1:0]      sel_ff, sel_in;
   logic [DIST_WIDTH:0]   bestd_ff, bestd_in;
   logic [COST_W-1:0]     cost_ff, cost_in;
   logic [COST_W-1:0]     best_cost_ff, best_cost_in;
   logic [MAX_CITIES-1:0] visited_ff, visited_in;
   logic                  best_bank_ff, best_bank_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CITY_W-1:0]     rsp_city_ff, rsp_city_in;
   logic [COST_OUT_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ram ports
   logic                  dist_we;
   logic [DIST_AW-1:0]    dist_waddr;
   logic [DIST_AW-1:0]    dist_raddr;
   logic [DIST_WIDTH-1:0] dist_rdata;
   logic                  tour_we;
   logic [TOUR_AW-1:0]    tour_waddr;
   logic [IDX_W-1:0]      tour_wdata;
   logic [TOUR_AW-1:0]    tour_raddr;
   logic [IDX_W-1:0]      tour_rdata;

   logic req_fire;
   logic out_free;

   mnnt_ram #(
      .WIDTH (DIST_WIDTH),
      .DEPTH (1 << DIST_AW)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (req.distance),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

   // two tour banks: the current tour builds in the bank that is not best,
   // so a better tour only flips the bank pointer
   mnnt_ram #(
      .WIDTH (IDX_W),
      .DEPTH (2 << IDX_W)
   ) u_tour_ram (
      .clock   (clock),
      .wr_en   (tour_we),
      .wr_addr (tour_waddr),
      .wr_data (tour_wdata),
      .rd_addr (tour_raddr),
      .rd_data (tour_rdata)
   );

   // clamp city count to 1..MAX_CITIES
   always_comb begin
      if (count_ff == '0) begin
         n_clamp = CSR_W'(1);
      end else if (count_ff > MAX_N) begin
         n_clamp = MAX_N;
      end else begin
         n_clamp = count_ff;
      end
   end
   assign n_last = IDX_W'(n_clamp - CSR_W'(1));

   assign req.ready     = (state_ff == S_LOAD);
   assign req_fire      = req.valid && req.ready;
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.city      = rsp_city_ff;
   assign rsp.tour_cost = rsp_cost_ff;
   assign rsp.last      = rsp_last_ff;

   assign dist_we    = req_fire;
   assign dist_waddr = {row_ff, col_ff};
   assign dist_raddr = (state_ff == S_CLOSE) ? {prev_ff, st_ff} : {prev_ff, i_ff};
   assign tour_raddr = {best_bank_ff, k_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      st_in        = st_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      prev_in      = prev_ff;
      sel_in       = sel_ff;
      bestd_in     = bestd_ff;
      cost_in      = cost_ff;
      best_cost_in = best_cost_ff;
      visited_in   = visited_ff;
      best_bank_in = best_bank_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_city_in  = rsp_city_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_last_in  = rsp_last_ff;
      tour_we      = 1'b0;
      tour_waddr   = {~best_bank_ff, k_ff};
      tour_wdata   = sel_ff;

      // shared compare: strictly smaller unvisited distance wins
      if (rd_vld_ff && !visited_ff[rd_idx_ff] && ({1'b0, dist_rdata} < bestd_ff)) begin
         bestd_in = {1'b0, dist_rdata};
         sel_in   = rd_idx_ff;
      end

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               if (col_ff == n_last) begin
                  col_in = '0;
                  if (row_ff == n_last) begin
                     row_in       = '0;
                     st_in        = '0;
                     best_cost_in = COST_W'(BEST_INIT);
                     state_in     = S_START;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         S_START: begin
            tour_we    = 1'b1;
            tour_waddr = {~best_bank_ff, {IDX_W{1'b0}}};
            tour_wdata = st_ff;
            visited_in = MAX_CITIES'(1) << st_ff;
            cost_in    = '0;
            prev_in    = st_ff;
            k_in       = IDX_W'(1);
            i_in       = '0;
            bestd_in   = '1;
            state_in   = (n_last == '0) ? S_TOUR_END : S_SCAN;
         end
         S_SCAN: begin
            // issue one distance read per cycle, compare it in the cycle after
            rd_vld_in = 1'b1;
            rd_idx_in = i_ff;
            if (i_ff == n_last) begin
               state_in = S_SCAN_END;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_SCAN_END: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            tour_we    = 1'b1;
            visited_in = visited_ff | (MAX_CITIES'(1) << sel_ff);
            cost_in    = cost_ff + COST_W'(bestd_ff[DIST_WIDTH-1:0]);
            prev_in    = sel_ff;
            if (k_ff == n_last) begin
               state_in = S_CLOSE;
            end else begin
               k_in     = k_ff + 1'b1;
               i_in     = '0;
               bestd_in = '1;
               state_in = S_SCAN;
            end
         end
         S_CLOSE: begin
            state_in = S_CLOSE_ADD;
         end
         S_CLOSE_ADD: begin
            // closing edge back to the start city
            cost_in  = cost_ff + COST_W'(dist_rdata);
            state_in = S_TOUR_END;
         end
         S_TOUR_END: begin
            if (cost_ff < best_cost_ff) begin
               best_cost_in = cost_ff;
               best_bank_in = ~best_bank_ff;
            end
            if (st_ff == n_last) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               st_in    = st_ff + 1'b1;
               state_in = S_START;
            end
         end
         S_OUT_RD: begin
            // read only once the result register is free at this edge
            if (out_free) begin
               state_in = S_OUT_LOAD;
            end
         end
         S_OUT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_city_in  = CITY_W'(tour_rdata) + CITY_W'(1);
            rsp_cost_in  = best_cost_ff[COST_OUT_W-1:0];
            rsp_last_in  = (k_ff == n_last);
            if (k_ff == n_last) begin
               state_in = S_LOAD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_OUT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (csr_wr_en) begin
         count_in = csr_wr_data;
         row_in   = '0;
         col_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= CSR_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         cost_ff      <= '0;
         best_cost_ff <= COST_W'(BEST_INIT);
         visited_ff   <= '0;
         best_bank_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cost_ff      <= cost_in;
         best_cost_ff <= best_cost_in;
         visited_ff   <= visited_in;
         best_bank_ff <= best_bank_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      st_ff       <= st_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      prev_ff     <= prev_in;
      sel_ff      <= sel_in;
      bestd_ff    <= bestd_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_city_ff <= rsp_city_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[rtl/mnnt_ram.sv]
module mnnt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/multi_start_nearest_neighbor_tour_tb.sv]
`timescale 1ns / 1ps

module multi_start_nearest_neighbor_tour_tb
   import mnnt_pkg::*;
();

   localparam int MAX_CITIES    = 64;
   localparam int DIST_WIDTH    = 16;
   localparam int RANDOM_ITEMS  = 290;
   // cycles of quiet after the last city before the csr may be touched
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 16;
   localparam int IDLE_PCT      = 8;
   localparam int MAX_REPORTS   = 10;

   // what the stimulus queue can hold
   typedef enum logic [1:0] {
      FEED_DIST,
      FEED_CSR,
      FEED_DRAIN
   } feed_kind_type;

   typedef struct {
      feed_kind_type         kind;
      logic [DIST_WIDTH-1:0] value;
   } feed_op_type;

   // how a run of matrix entries is filled
   typedef enum logic [1:0] {
      FILL_WIDE,
      FILL_TIES,
      FILL_EDGES,
      FILL_HIGH
   } fill_style_type;

   // one city of the predicted best tour
   typedef struct {
      logic [CITY_W-1:0]     city;
      logic [COST_OUT_W-1:0] cost;
      logic                  last;
   } tour_point_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   mnnt_req_if #(.DIST_WIDTH(DIST_WIDTH)) req_ch ();
   mnnt_rsp_if rsp_ch ();

   multi_start_nearest_neighbor_tour #(
      .MAX_CITIES(MAX_CITIES),
      .DIST_WIDTH(DIST_WIDTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // stimulus still to be driven and cities still to arrive
   feed_op_type    feed_ops[$];
   tour_point_type tour_points[$];

   // predictor state: its own copy of the matrix, load position and city count
   logic [DIST_WIDTH-1:0] dist_mat [MAX_CITIES][MAX_CITIES];
   int                    cities_n;
   int                    load_pos;

   int   entries_loaded;
   int   points_seen;
   int   mismatch_count;
   int   quiet_cycles;
   logic req_taken;

   always #1 clock = ~clock;

   // greedy tour from every start, keep the cheapest closed tour
   function automatic void plan_best_tour();
      logic [5:0]            walk [MAX_CITIES];
      logic [5:0]            best_walk [MAX_CITIES];
      logic [MAX_CITIES-1:0] seen;
      logic [22:0]           walk_cost;
      logic [22:0]           best_cost;
      logic [16:0]           near_d;
      int                    near_c;
      int                    here;
      tour_point_type        pt;
      best_cost = BEST_INIT;
      best_walk = walk;
      for (int s = 0; s < cities_n; s++) begin
         seen = '0;
         seen[s] = 1'b1;
         walk[0] = 6'(s);
         walk_cost = '0;
         for (int k = 1; k < cities_n; k++) begin
            here = walk[k-1];
            near_d = '1;
            near_c = 0;
            // strict compare: lowest index wins a tie
            for (int c = 0; c < cities_n; c++) begin
               if (!seen[c] && {1'b0, dist_mat[here][c]} < near_d) begin
                  near_d = {1'b0, dist_mat[here][c]};
                  near_c = c;
               end
            end
            walk[k] = 6'(near_c);
            seen[near_c] = 1'b1;
            walk_cost = walk_cost + 23'(near_d);
         end
         // closing edge back to the start
         if (cities_n > 1)
            walk_cost = walk_cost + 23'(dist_mat[walk[cities_n-1]][s]);
         // earliest start wins a tie
         if (walk_cost < best_cost) begin
            best_cost = walk_cost;
            best_walk = walk;
         end
      end
      for (int k = 0; k < cities_n; k++) begin
         pt.city = CITY_W'(best_walk[k]) + 1'b1;
         pt.cost = best_cost[COST_OUT_W-1:0];
         pt.last = (k == cities_n - 1);
         tour_points.push_back(pt);
      end
   endfunction

   function automatic void check_field(string name, int idx, int want, int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("city item %0d: %s expected %0d, got %0d", idx, name, want, got);
      end
   endfunction

   function automatic void queue_dist(int v);
      feed_op_type op;
      op.kind = FEED_DIST;
      op.value = DIST_WIDTH'(v);
      feed_ops.push_back(op);
   endfunction

   function automatic void queue_csr(int v);
      feed_op_type op;
      op.kind = FEED_CSR;
      op.value = DIST_WIDTH'(v);
      feed_ops.push_back(op);
   endfunction

   function automatic void queue_drain();
      feed_op_type op;
      op.kind = FEED_DRAIN;
      op.value = '0;
      feed_ops.push_back(op);
   endfunction

   function automatic void queue_entries(int count, fill_style_type style);
      feed_op_type op;
      op.kind = FEED_DIST;
      for (int e = 0; e < count; e++) begin
         case (style)
            FILL_WIDE: begin
               op.value = DIST_WIDTH'($urandom);
            end
            FILL_TIES: begin
               op.value = DIST_WIDTH'($urandom_range(3));
            end
            FILL_EDGES: begin
               op.value = $urandom_range(1) ? '1 : '0;
            end
            default: begin
               // upper half only, pushes long tours toward the top cost bits
               op.value = 16'h8000 | DIST_WIDTH'($urandom_range(32767));
            end
         endcase
         feed_ops.push_back(op);
      end
   endfunction

   // sampling side: predictor update and result check at the rising edge
   always @(posedge clock) begin
      tour_point_type want;
      if (reset) begin
         cities_n = MAX_CITIES;
         load_pos = 0;
         req_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_ch.valid && req_ch.ready;

         // result check first, so a city never meets the tour queued at this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (tour_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("city item %0d: unexpected, city %0d cost %0d last %0d",
                           points_seen, rsp_ch.city, rsp_ch.tour_cost, rsp_ch.last);
            end else begin
               want = tour_points.pop_front();
               check_field("city", points_seen, want.city, rsp_ch.city);
               check_field("tour_cost", points_seen, want.cost, rsp_ch.tour_cost);
               check_field("last", points_seen, want.last, rsp_ch.last);
            end
            points_seen++;
         end

         // a city count write clamps n and restarts the load
         if (csr_wr_en) begin
            if (csr_wr_data == 0)
               cities_n = 1;
            else if (csr_wr_data > MAX_CITIES)
               cities_n = MAX_CITIES;
            else
               cities_n = csr_wr_data;
            load_pos = 0;
         end

         if (req_taken) begin
            dist_mat[load_pos / cities_n][load_pos % cities_n] = req_ch.distance;
            load_pos++;
            entries_loaded++;
            // last entry of the matrix: the whole tour is known now
            if (load_pos == cities_n * cities_n) begin
               load_pos = 0;
               plan_best_tour();
            end
         end

         if (tour_points.size() != 0)
            quiet_cycles = 0;
         else if (quiet_cycles < 1000)
            quiet_cycles++;
      end
   end

   // driving side: everything changes at the falling edge
   always @(negedge clock) begin
      logic                  offer;
      logic [DIST_WIDTH-1:0] offer_d;
      logic                  wr;
      logic [CSR_W-1:0]      wr_d;
      logic                  settled;
      logic                  send_calm;
      logic                  recv_calm;
      if (!reset) begin
         // an item not taken at the last edge stays on the wires
         offer = req_ch.valid && !req_taken;
         offer_d = req_ch.distance;
         wr = 1'b0;
         wr_d = csr_wr_data;
         settled = (tour_points.size() == 0) && (quiet_cycles >= SETTLE_CYCLES);
         // stretches without any idling on either side
         send_calm = (entries_loaded >= 150) && (entries_loaded < 260);
         recv_calm = (points_seen >= 80) && (points_seen < 200);
         if (!offer && !csr_wr_en && feed_ops.size() != 0) begin
            case (feed_ops[0].kind)
               FEED_DIST: begin
                  if (send_calm || $urandom_range(99) >= IDLE_PCT) begin
                     offer = 1'b1;
                     offer_d = feed_ops[0].value;
                     void'(feed_ops.pop_front());
                  end
               end
               FEED_CSR: begin
                  // csr only while the block is idle
                  if (settled) begin
                     wr = 1'b1;
                     wr_d = feed_ops[0].value[CSR_W-1:0];
                     void'(feed_ops.pop_front());
                  end
               end
               default: begin
                  // hold the sender until every city has come back
                  if (settled)
                     void'(feed_ops.pop_front());
               end
            endcase
         end
         req_ch.valid <= offer;
         req_ch.distance <= offer_d;
         csr_wr_en <= wr;
         csr_wr_data <= wr_d;
         rsp_ch.ready <= recv_calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // stimulus, reset and end of run
   initial begin
      int             cur_n;
      int             n_pick;
      int             roll;
      int             cut;
      int             rand_items;
      logic           mid_load;
      fill_style_type style;

      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.distance = '0;
      rsp_ch.ready = 1'b0;
      entries_loaded = 0;
      points_seen = 0;
      mismatch_count = 0;

      // single city through a zero count: city 1, no cost
      queue_csr(0);
      queue_dist(16'hFFFF);
      queue_dist(0);
      queue_csr(1);
      queue_dist(16'h1234);
      // two cities, both starts cost the same: earliest start kept
      queue_csr(2);
      queue_dist(0);
      queue_dist(16'hFFFF);
      queue_dist(16'hFFFF);
      queue_dist(0);
      // count written mid-load: load restarts at the first entry
      queue_csr(3);
      repeat (4) queue_dist(9);
      queue_csr(3);
      // all equal: lowest index wins every step
      repeat (9) queue_dist(7);
      // count above the limit acts as the limit, load cut short
      queue_csr(127);
      repeat (12) queue_dist(5);

      // random part: mostly whole matrices, a few broken loads
      cur_n = MAX_CITIES;
      mid_load = 1'b1;
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 60)
            n_pick = $urandom_range(5, 2);
         else if (roll < 85)
            n_pick = $urandom_range(9, 6);
         else if (roll < 93)
            n_pick = 1;
         else
            n_pick = $urandom_range(12, 10);
         if (mid_load || n_pick != cur_n || $urandom_range(3) == 0) begin
            queue_csr((n_pick == 1 && $urandom_range(1) == 1) ? 0 : n_pick);
            cur_n = n_pick;
            mid_load = 1'b0;
         end
         if ($urandom_range(9) == 0)
            queue_drain();
         style = fill_style_type'($urandom_range(3));
         if (n_pick > 1 && $urandom_range(99) < 8) begin
            // abandoned load, the next csr write throws it away
            cut = $urandom_range(n_pick * n_pick - 1, 1);
            queue_entries(cut, style);
            rand_items += cut;
            mid_load = 1'b1;
         end else begin
            queue_entries(n_pick * n_pick, style);
            rand_items += n_pick * n_pick;
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (feed_ops.size() != 0 || req_ch.valid || csr_wr_en || tour_points.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("multi_start_nearest_neighbor_tour_tb: done, clean");
      else
         $display("multi_start_nearest_neighbor_tour_tb: done, errors");
      $finish;
   end

   // watchdog, well above the slowest legal run
   initial begin
      #200_000;
      $display("multi_start_nearest_neighbor_tour_tb: done, errors");
      $finish;
   end

endmodule
